@@ hdl/fcol_pkg.sv @@
// shared types, constants and command codes for the ordered list
package fcol_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 64;
  localparam int PAY_BITS = 64;
  localparam int POS_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_GET    = 3'd3;
  localparam logic [2:0] CMD_UPDATE = 3'd4;
  localparam logic [2:0] CMD_FIND   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BADPOS   = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef logic [1:0] sel_t;
  localparam sel_t SEL_HOLD = 2'd0;
  localparam sel_t SEL_LOAD = 2'd1;
  localparam sel_t SEL_UP   = 2'd2;  // take the entry of the lower neighbor
  localparam sel_t SEL_DOWN = 2'd3;  // take the entry of the upper neighbor

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [PAY_BITS-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic             upd;
    logic [POS_W-1:0] pos;
  } shift_ctl_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  position;
    logic        at_end;
    logic [63:0] item_key;
    logic [63:0] item_payload;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  found_position;
    logic [63:0] out_key;
    logic [63:0] out_payload;
    logic [4:0]  entry_count;
    logic        is_empty;
  } rsp_t;

endpackage

@@ hdl/fcol_if.sv @@
// valid/ready channel interfaces for commands and results
interface fcol_cmd_if;
  logic          valid;
  logic          ready;
  fcol_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fcol_rsp_if;
  logic          valid;
  logic          ready;
  fcol_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/fcol_cell.sv @@
// one list slot: holds an entry, loads or shifts from a neighbor, compares key
module fcol_cell (
  input  logic                          clk,
  input  fcol_pkg::sel_t                sel,
  input  fcol_pkg::entry_t              load_entry,
  input  fcol_pkg::entry_t              lower_entry,
  input  fcol_pkg::entry_t              upper_entry,
  input  logic [fcol_pkg::KEY_BITS-1:0] search_key,
  output fcol_pkg::entry_t              entry,
  output logic                          match
);

  fcol_pkg::entry_t entry_r;
  fcol_pkg::entry_t entry_nxt;

  always_comb begin
    case (sel)
      fcol_pkg::SEL_LOAD: entry_nxt = load_entry;
      fcol_pkg::SEL_UP:   entry_nxt = lower_entry;
      fcol_pkg::SEL_DOWN: entry_nxt = upper_entry;
      default:            entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = (entry_r.key == search_key);

endmodule

@@ hdl/fcol_chain.sv @@
// row of cells with per-slot shift select, lowest-match search and entry taps
module fcol_chain (
  input  logic                                   clk,
  input  fcol_pkg::shift_ctl_t                   ctl,
  input  fcol_pkg::entry_t                       load_entry,
  input  logic [fcol_pkg::KEY_BITS-1:0]          search_key,
  input  logic [fcol_pkg::CNT_W-1:0]             count,
  output fcol_pkg::entry_t [fcol_pkg::DEPTH-1:0] entries,
  output logic                                   find_hit,
  output logic [fcol_pkg::POS_W-1:0]             find_pos
);

  logic [fcol_pkg::DEPTH-1:0] match;
  logic [fcol_pkg::DEPTH-1:0] hit;

  for (genvar i = 0; i < fcol_pkg::DEPTH; i++) begin : g_cell
    fcol_pkg::sel_t   sel;
    fcol_pkg::entry_t lower;
    fcol_pkg::entry_t upper;

    always_comb begin
      sel = fcol_pkg::SEL_HOLD;
      if ((ctl.ins || ctl.upd) && (fcol_pkg::POS_W'(i) == ctl.pos)) begin
        sel = fcol_pkg::SEL_LOAD;
      end else if (ctl.ins && (fcol_pkg::POS_W'(i) > ctl.pos)) begin
        sel = fcol_pkg::SEL_UP;
      end else if (ctl.del && (fcol_pkg::POS_W'(i) >= ctl.pos) && (i < fcol_pkg::DEPTH - 1)) begin
        sel = fcol_pkg::SEL_DOWN;
      end
    end

    if (i == 0) begin : g_first
      assign lower = load_entry;
    end else begin : g_lower
      assign lower = entries[i-1];
    end

    if (i == fcol_pkg::DEPTH - 1) begin : g_last
      assign upper = entries[i];
    end else begin : g_upper
      assign upper = entries[i+1];
    end

    fcol_cell u_cell (
      .clk         (clk),
      .sel         (sel),
      .load_entry  (load_entry),
      .lower_entry (lower),
      .upper_entry (upper),
      .search_key  (search_key),
      .entry       (entries[i]),
      .match       (match[i])
    );

    // only occupied slots take part in the search
    assign hit[i] = match[i] && (fcol_pkg::CNT_W'(i) < count);
  end

  // priority pick of the lowest matching slot
  always_comb begin
    find_pos = '0;
    for (int i = fcol_pkg::DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        find_pos = fcol_pkg::POS_W'(i);
      end
    end
  end

  assign find_hit = |hit;

endmodule

@@ hdl/fixed_capacity_ordered_list_top.sv @@
// ordered list top: command decode, entry count and registered result
// the result of an item is written into the output register when the item is accepted
// throughput: one item per cycle; all cells shift, load and compare in the same cycle
// a stalled result stalls the input only while the output register is full and not taken
// reset clears the entry count and the output valid; cell contents stay undefined
module fixed_capacity_ordered_list_top (
  input  logic      clk,
  input  logic      rst_n,
  fcol_cmd_if.sink   in_if,
  fcol_rsp_if.source out_if
);

  logic [fcol_pkg::CNT_W-1:0]             count_r;
  logic [fcol_pkg::CNT_W-1:0]             count_nxt;
  logic                                   out_valid_r;
  logic                                   out_valid_nxt;
  fcol_pkg::rsp_t                         rsp_r;
  fcol_pkg::rsp_t                         rsp_nxt;
  fcol_pkg::shift_ctl_t                   ctl;
  fcol_pkg::shift_ctl_t                   ctl_gated;
  fcol_pkg::entry_t                       load_entry;
  fcol_pkg::entry_t [fcol_pkg::DEPTH-1:0] entries;
  fcol_pkg::entry_t                       read_entry;
  logic [fcol_pkg::KEY_BITS-1:0]          search_key;
  logic                                   find_hit;
  logic [fcol_pkg::POS_W-1:0]             find_pos;
  logic                                   accept;
  logic                                   full;
  logic                                   in_range;
  logic [fcol_pkg::CNT_W-1:0]             pos_ext;
  logic [fcol_pkg::CNT_W-1:0]             ins_pos;
  fcol_pkg::cmd_t                         cmd;

  assign cmd          = in_if.data;
  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign accept       = in_if.valid && in_if.ready;

  assign search_key         = cmd.item_key[fcol_pkg::KEY_BITS-1:0];
  assign load_entry.key     = cmd.item_key[fcol_pkg::KEY_BITS-1:0];
  assign load_entry.payload = cmd.item_payload[fcol_pkg::PAY_BITS-1:0];

  assign full     = (count_r == fcol_pkg::CNT_W'(fcol_pkg::DEPTH));
  assign pos_ext  = fcol_pkg::CNT_W'(cmd.position);
  assign ins_pos  = cmd.at_end ? count_r : pos_ext;
  assign in_range = (pos_ext < count_r);
  assign read_entry = entries[cmd.position[fcol_pkg::POS_W-1:0]];

  always_comb begin
    count_nxt = count_r;
    ctl       = '0;
    rsp_nxt   = '0;
    rsp_nxt.status = fcol_pkg::ST_OK;
    case (cmd.command)
      fcol_pkg::CMD_CLEAR: begin
        count_nxt = '0;
      end
      fcol_pkg::CMD_INSERT: begin
        if (full) begin
          rsp_nxt.status = fcol_pkg::ST_FULL;
        end else if (ins_pos > count_r) begin
          rsp_nxt.status = fcol_pkg::ST_BADPOS;
        end else begin
          ctl.ins   = 1'b1;
          ctl.pos   = ins_pos[fcol_pkg::POS_W-1:0];
          count_nxt = count_r + 1'b1;
        end
      end
      fcol_pkg::CMD_DELETE: begin
        if (in_range) begin
          ctl.del   = 1'b1;
          ctl.pos   = cmd.position[fcol_pkg::POS_W-1:0];
          count_nxt = count_r - 1'b1;
        end else begin
          rsp_nxt.status = fcol_pkg::ST_BADPOS;
        end
      end
      fcol_pkg::CMD_GET: begin
        if (in_range) begin
          rsp_nxt.out_key     = 64'(read_entry.key);
          rsp_nxt.out_payload = 64'(read_entry.payload);
        end else begin
          rsp_nxt.status = fcol_pkg::ST_BADPOS;
        end
      end
      fcol_pkg::CMD_UPDATE: begin
        if (in_range) begin
          ctl.upd = 1'b1;
          ctl.pos = cmd.position[fcol_pkg::POS_W-1:0];
        end else begin
          rsp_nxt.status = fcol_pkg::ST_BADPOS;
        end
      end
      fcol_pkg::CMD_FIND: begin
        if (find_hit) begin
          rsp_nxt.found_position = 4'(find_pos);
        end else begin
          rsp_nxt.status = fcol_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        // unused codes leave the list alone
      end
    endcase
    rsp_nxt.entry_count = 5'(count_nxt);
    rsp_nxt.is_empty    = (count_nxt == '0);
  end

  // the cells move only when the item is actually taken
  always_comb begin
    ctl_gated     = ctl;
    ctl_gated.ins = ctl.ins && accept;
    ctl_gated.del = ctl.del && accept;
    ctl_gated.upd = ctl.upd && accept;
  end

  fcol_chain u_chain (
    .clk        (clk),
    .ctl        (ctl_gated),
    .load_entry (load_entry),
    .search_key (search_key),
    .count      (count_r),
    .entries    (entries),
    .find_hit   (find_hit),
    .find_pos   (find_pos)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = rsp_r;

endmodule

@@ test/testbench.sv @@
// testbench for the ordered list: directed and random commands checked against a list predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fcol_pkg::*;

  // command codes the block ignores
  localparam logic [2:0] CMD_RSVD_A = 3'd6;
  localparam logic [2:0] CMD_RSVD_B = 3'd7;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk;
  logic rst_n;

  fcol_cmd_if cmd_ch ();
  fcol_rsp_if rsp_ch ();

  fixed_capacity_ordered_list_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (cmd_ch),
    .out_if (rsp_ch)
  );

  // predicted list contents
  logic [KEY_BITS-1:0] list_keys     [DEPTH];
  logic [PAY_BITS-1:0] list_payloads [DEPTH];
  int                  list_count;

  rsp_t        pending_rsps [$];
  int          fail_count;
  int          burst_left;
  logic [63:0] key_pool [8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic rsp_t apply_command(cmd_t c);
    rsp_t        r;
    int unsigned p;
    int          a;
    r = '0;
    r.status = ST_OK;
    p = c.position;
    case (c.command)
      CMD_CLEAR: list_count = 0;
      CMD_INSERT: begin
        if (list_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (c.at_end) p = list_count;
          if (p > list_count) begin
            r.status = ST_BADPOS;
          end else begin
            for (a = list_count; a > int'(p); a--) begin
              list_keys[a]     = list_keys[a-1];
              list_payloads[a] = list_payloads[a-1];
            end
            list_keys[p]     = c.item_key;
            list_payloads[p] = c.item_payload;
            list_count++;
          end
        end
      end
      CMD_DELETE: begin
        if (p >= list_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (a = p; a + 1 < list_count; a++) begin
            list_keys[a]     = list_keys[a+1];
            list_payloads[a] = list_payloads[a+1];
          end
          list_count--;
        end
      end
      CMD_GET: begin
        if (p >= list_count) begin
          r.status = ST_BADPOS;
        end else begin
          r.out_key     = list_keys[p];
          r.out_payload = list_payloads[p];
        end
      end
      CMD_UPDATE: begin
        if (p >= list_count) begin
          r.status = ST_BADPOS;
        end else begin
          list_keys[p]     = c.item_key;
          list_payloads[p] = c.item_payload;
        end
      end
      CMD_FIND: begin
        r.status = ST_NOTFOUND;
        for (a = 0; a < list_count; a++) begin
          if (list_keys[a] == c.item_key) begin
            r.status         = ST_OK;
            r.found_position = 4'(a);
            break;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = 5'(list_count);
    r.is_empty    = (list_count == 0);
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] op, int pos, logic last,
                                    logic [63:0] key, logic [63:0] pay);
    cmd_t c;
    c.command      = op;
    c.position     = 4'(pos);
    c.at_end       = last;
    c.item_key     = key;
    c.item_payload = pay;
    return c;
  endfunction

  // drive at the falling edge and hold until the item is taken
  task automatic send_item(input cmd_t c);
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    pending_rsps.push_back(apply_command(c));
    @(negedge clk);
  endtask

  // bursts of random length, random gaps in between
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left = $urandom_range(1, 30);
  endtask

  task automatic issue(input cmd_t c);
    send_item(c);
    pace_sender();
  endtask

  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (a !== e) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t exp;
    if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_rsps.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, rsp_ch.data);
        fail_count++;
      end else begin
        exp = pending_rsps.pop_front();
        check_field("status", 64'(exp.status), 64'(rsp_ch.data.status));
        check_field("found_position", 64'(exp.found_position),
                    64'(rsp_ch.data.found_position));
        check_field("out_key", exp.out_key, rsp_ch.data.out_key);
        check_field("out_payload", exp.out_payload, rsp_ch.data.out_payload);
        check_field("entry_count", 64'(exp.entry_count), 64'(rsp_ch.data.entry_count));
        check_field("is_empty", 64'(exp.is_empty), 64'(rsp_ch.data.is_empty));
      end
    end
  end

  // result stalls: one of four styles, picked anew at random
  initial begin
    int cyc;
    int stall_mode;
    int stall_left;
    cyc = 0;
    stall_mode = 0;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cyc % 256 == 0) stall_mode = $urandom_range(0, 3);
      cyc++;
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2: begin
          if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
          end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 12);
          end
        end
        default: rsp_ch.ready <= (cyc % 7) >= 2;
      endcase
    end
  end

  task automatic test_empty_list();
    issue(make_cmd(CMD_FIND, 0, 1'b0, 64'd0, 64'd0));
    issue(make_cmd(CMD_GET, 0, 1'b0, 64'd0, 64'd0));
    issue(make_cmd(CMD_DELETE, 0, 1'b0, 64'd0, 64'd0));
    issue(make_cmd(CMD_UPDATE, 0, 1'b0, ALL_ONES, ALL_ONES));
    issue(make_cmd(CMD_INSERT, 1, 1'b0, 64'h11, 64'h22));
  endtask

  // builds A, B, B, C: append with a stray position, front, append at count, middle
  task automatic test_insert_positions();
    issue(make_cmd(CMD_INSERT, 15, 1'b1, ALL_ONES, 64'd0));
    issue(make_cmd(CMD_INSERT, 0, 1'b0, 64'd0, ALL_ONES));
    issue(make_cmd(CMD_INSERT, 2, 1'b0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210));
    issue(make_cmd(CMD_INSERT, 1, 1'b0, ALL_ONES, 64'h5A5A_5A5A_A5A5_A5A5));
  endtask

  task automatic test_reads();
    issue(make_cmd(CMD_GET, 0, 1'b0, 64'd0, 64'd0));
    issue(make_cmd(CMD_GET, 3, 1'b1, 64'd0, 64'd0));
    issue(make_cmd(CMD_FIND, 15, 1'b0, ALL_ONES, 64'd0));
    issue(make_cmd(CMD_FIND, 0, 1'b0, 64'hDEAD_BEEF_0000_0001, 64'd0));
  endtask

  task automatic test_modify();
    issue(make_cmd(CMD_UPDATE, 3, 1'b0, 64'h8000_0000_0000_0000, 64'h1));
    issue(make_cmd(CMD_DELETE, 0, 1'b0, 64'd0, 64'd0));
    issue(make_cmd(CMD_DELETE, 2, 1'b0, 64'd0, 64'd0));
    issue(make_cmd(CMD_GET, 3, 1'b0, 64'd0, 64'd0));
    issue(make_cmd(CMD_GET, 15, 1'b0, 64'd0, 64'd0));
  endtask

  task automatic test_unused_codes();
    issue(make_cmd(CMD_RSVD_A, 0, 1'b0, ALL_ONES, ALL_ONES));
    issue(make_cmd(CMD_RSVD_B, 15, 1'b1, 64'd0, 64'd0));
  endtask

  task automatic test_clear();
    issue(make_cmd(CMD_CLEAR, 7, 1'b1, ALL_ONES, ALL_ONES));
    issue(make_cmd(CMD_FIND, 0, 1'b0, 64'd0, 64'd0));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // phase 0 fills the list, phase 1 drains it, phase 2 mixes
  function automatic cmd_t random_cmd(int phase);
    cmd_t c;
    int   r;
    int   ins_w;
    int   del_w;
    r = $urandom_range(0, 99);
    case (phase)
      0:       begin ins_w = 52; del_w = 8;  end
      1:       begin ins_w = 12; del_w = 45; end
      default: begin ins_w = 28; del_w = 22; end
    endcase
    c.at_end       = 1'($urandom_range(0, 1));
    c.item_key     = ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, 7)] : rand64();
    c.item_payload = ($urandom_range(0, 15) == 0) ? ALL_ONES : rand64();
    if (r < 1) c.command = CMD_CLEAR;
    else if (r < 4) c.command = $urandom_range(0, 1) ? CMD_RSVD_A : CMD_RSVD_B;
    else if (r < 4 + ins_w) c.command = CMD_INSERT;
    else if (r < 4 + ins_w + del_w) c.command = CMD_DELETE;
    else begin
      case ($urandom_range(0, 2))
        0:       c.command = CMD_GET;
        1:       c.command = CMD_UPDATE;
        default: c.command = CMD_FIND;
      endcase
    end
    if (c.command == CMD_INSERT) c.at_end = ($urandom_range(0, 3) == 0);
    // mostly in range, sometimes anywhere
    if ($urandom_range(0, 3) == 0)
      c.position = 4'($urandom_range(0, 15));
    else if (c.command == CMD_INSERT)
      c.position = 4'($urandom_range(0, (list_count > 15) ? 15 : list_count));
    else
      c.position = (list_count == 0) ? 4'd0 : 4'($urandom_range(0, list_count - 1));
    if (c.command == CMD_FIND && list_count > 0 && $urandom_range(0, 1) == 0)
      c.item_key = list_keys[$urandom_range(0, list_count - 1)];
    return c;
  endfunction

  task automatic test_random_traffic(input int n_items);
    cmd_t c;
    int   done;
    int   phase;
    done = 0;
    phase = 0;
    key_pool[0] = 64'd0;
    key_pool[1] = ALL_ONES;
    for (int k = 2; k < 8; k++) key_pool[k] = rand64();
    while (done < n_items) begin
      if (done % 80 == 0) phase = $urandom_range(0, 2);
      c = random_cmd(phase);
      issue(c);
      if (c.command != CMD_RSVD_A && c.command != CMD_RSVD_B) done++;
    end
  endtask

  initial begin
    int waited;
    fail_count = 0;
    burst_left = 0;
    list_count = 0;
    rst_n = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_list();
    test_insert_positions();
    test_reads();
    test_modify();
    test_unused_codes();
    test_clear();
    test_random_traffic(930);

    cmd_ch.valid <= 1'b0;
    waited = 0;
    while (pending_rsps.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (pending_rsps.size() != 0)
      $display("%0t: %0d results never arrived", $time, pending_rsps.size());
    if (fail_count == 0 && pending_rsps.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
